// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define PGN_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that, once seen, must be followed by another in the next cycle.
`define PGN_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- hdl/pgn_pkg.sv -----
// Types and constants of the 2D gradient noise block.
package pgn_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CELL_W     = 11;
	localparam int WEIGHT_W   = 16;
	localparam int ENTRIES_W  = 9;
	localparam int HASH_W     = 28;
	localparam int OUT_W      = 27;

	localparam int unsigned HASH_MUL_I = 42043;
	localparam int unsigned HASH_MUL_J = 15299;
	localparam int unsigned FIX_ONE    = 65536;
	localparam int unsigned CELL_MAX   = 1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CELL_SIZE     = 2'd0,
		REG_LAYER_WEIGHT  = 2'd1,
		REG_TABLE_ENTRIES = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_EVAL = 1'b1
	} func_t;

endpackage

// ----- hdl/pgn_div.sv -----
// Pipelined restoring divider: several lanes share one divisor and a sideband tag.
module pgn_div #(
	parameter int LANES  = 2,
	parameter int NUM_W  = 16,
	parameter int DEN_W  = 11,
	parameter int TAG_W  = 1,
	parameter int STAGES = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [LANES-1:0][DEN_W-1:0]     r0,
	input  logic [LANES-1:0][NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]                den,
	input  logic [TAG_W-1:0]                tag,
	output logic                            out_valid,
	output logic [LANES-1:0][NUM_W-1:0]     quot,
	output logic [LANES-1:0][DEN_W-1:0]     rem,
	output logic [TAG_W-1:0]                tag_out
);

	// NUM_W must be a multiple of STAGES
	localparam int STEP = NUM_W / STAGES;

	logic                        v_s   [1:STAGES];
	logic [LANES-1:0][DEN_W-1:0] rem_s [1:STAGES];
	logic [LANES-1:0][NUM_W-1:0] nq_s  [1:STAGES];
	logic [TAG_W-1:0]            tag_s [1:STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic                        prv_v;
		logic [LANES-1:0][DEN_W-1:0] prv_rem;
		logic [LANES-1:0][NUM_W-1:0] prv_nq;
		logic [TAG_W-1:0]            prv_tag;
		logic [LANES-1:0][DEN_W-1:0] rem_nxt;
		logic [LANES-1:0][NUM_W-1:0] nq_nxt;
		logic [DEN_W:0]              part;
		logic [DEN_W-1:0]            r;
		logic [NUM_W-1:0]            q;

		if (g == 0) begin : g_first
			assign prv_v   = in_valid;
			assign prv_rem = r0;
			assign prv_nq  = num;
			assign prv_tag = tag;
		end else begin : g_next
			assign prv_v   = v_s[g];
			assign prv_rem = rem_s[g];
			assign prv_nq  = nq_s[g];
			assign prv_tag = tag_s[g];
		end

		// shift in one numerator bit per step, quotient bits fill from the bottom
		always_comb begin
			part    = '0;
			r       = '0;
			q       = '0;
			rem_nxt = '0;
			nq_nxt  = '0;
			for (int l = 0; l < LANES; l++) begin
				r = prv_rem[l];
				q = prv_nq[l];
				for (int k = 0; k < STEP; k++) begin
					part = {r, q[NUM_W-1]};
					q    = {q[NUM_W-2:0], 1'b0};
					if (part >= {1'b0, den}) begin
						part = part - {1'b0, den};
						q[0] = 1'b1;
					end
					r = part[DEN_W-1:0];
				end
				rem_nxt[l] = r;
				nq_nxt[l]  = q;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= prv_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= rem_nxt;
				nq_s[g+1]  <= nq_nxt;
				tag_s[g+1] <= prv_tag;
			end
		end
	end

	assign out_valid = v_s[STAGES];
	assign quot      = nq_s[STAGES];
	assign rem       = rem_s[STAGES];
	assign tag_out   = tag_s[STAGES];

endmodule

// ----- hdl/perlin_gradient_noise_2d.sv -----
// Throughput: one request per cycle; the whole pipeline advances together and
// holds only while a finished result waits on out_stall.
// The two divider chains (position mod cell, then offset fraction) set the depth.
// Reset clears valid bits and loads the registers to cell 16, weight 1.0, 256 entries;
// the gradient table is not cleared and must be loaded before use.
module perlin_gradient_noise_2d
	import pgn_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       func,
	input  logic [15:0]                pixel_x,
	input  logic [15:0]                pixel_y,
	input  logic [11:0]                cell_x,
	input  logic [11:0]                cell_y,
	input  logic [7:0]                 grad_index,
	input  logic signed [15:0]         grad_x,
	input  logic signed [15:0]         grad_y,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [OUT_W-1:0]    noise_value,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	typedef struct packed {
		logic [7:0]  grad_index;
		logic [15:0] grad_x;
		logic [15:0] grad_y;
	} load_tag_t;

	typedef struct packed {
		logic                  func;
		load_tag_t             load;
		logic                  full_x;
		logic                  full_y;
		logic [3:0][IDX_W-1:0] idx;
	} frac_tag_t;

	// ---------------- configuration ----------------
	logic [CELL_W-1:0]    cell_size_q;
	logic [WEIGHT_W-1:0]  layer_weight_q;
	logic [ENTRIES_W-1:0] table_entries_q;
	logic [CELL_W-1:0]    cs;
	logic [ENTRIES_W-1:0] n_ent;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q     <= CELL_W'(16);
			layer_weight_q  <= WEIGHT_W'(256);
			table_entries_q <= ENTRIES_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CELL_SIZE:     cell_size_q     <= cfg_data[CELL_W-1:0];
				REG_LAYER_WEIGHT:  layer_weight_q  <= cfg_data[WEIGHT_W-1:0];
				REG_TABLE_ENTRIES: table_entries_q <= cfg_data[ENTRIES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cs = cell_size_q;
		if (cell_size_q == '0) cs = CELL_W'(1);
		if (32'(cell_size_q) > CELL_MAX) cs = CELL_W'(CELL_MAX);
		n_ent = table_entries_q;
		if (table_entries_q == '0) n_ent = ENTRIES_W'(1);
		if (32'(table_entries_q) > TABLE_DEPTH) n_ent = ENTRIES_W'(TABLE_DEPTH);
	end

	// ---------------- pipeline control ----------------
	logic out_valid_q;
	logic en;

	assign en        = !(out_valid_q && out_stall);
	assign in_stall  = !en;
	assign out_valid = out_valid_q;

	// ---------------- stage 1: capture, corner hash sums ----------------
	logic                   v_s1;
	logic                   func_s1;
	logic [1:0][15:0]       pix_s1;
	load_tag_t              load_s1;
	logic [3:0][HASH_W-1:0] hsum_s1;
	logic [HASH_W-1:0]      hbase;

	assign hbase = HASH_W'(cell_x) * HASH_W'(HASH_MUL_I)
		+ HASH_W'(cell_y) * HASH_W'(HASH_MUL_J);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1            <= func;
			pix_s1             <= {pixel_y, pixel_x};
			load_s1.grad_index <= grad_index;
			load_s1.grad_x     <= grad_x;
			load_s1.grad_y     <= grad_y;
			// corner order: (i,j), (i+1,j), (i,j+1), (i+1,j+1)
			hsum_s1[0] <= hbase;
			hsum_s1[1] <= hbase + HASH_W'(HASH_MUL_I);
			hsum_s1[2] <= hbase + HASH_W'(HASH_MUL_J);
			hsum_s1[3] <= hbase + HASH_W'(HASH_MUL_I + HASH_MUL_J);
		end
	end

	// ---------------- stages 2..5: position mod cell, hash mod entries ----------------
	logic                      mod_v;
	logic [1:0][15:0]          mod_quot;
	logic [1:0][CELL_W-1:0]    mod_rem;
	load_tag_t                 mod_tag;
	logic                      hash_v;
	logic [3:0][HASH_W-1:0]    hash_quot;
	logic [3:0][ENTRIES_W-1:0] hash_rem;
	logic                      hash_tag;

	pgn_div #(
		.LANES(2), .NUM_W(16), .DEN_W(CELL_W), .TAG_W($bits(load_tag_t)), .STAGES(4)
	) u_mod_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .r0('0), .num(pix_s1), .den(cs), .tag(load_s1),
		.out_valid(mod_v), .quot(mod_quot), .rem(mod_rem), .tag_out(mod_tag)
	);

	pgn_div #(
		.LANES(4), .NUM_W(HASH_W), .DEN_W(ENTRIES_W), .TAG_W(1), .STAGES(4)
	) u_hash_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .r0('0), .num(hsum_s1), .den(n_ent), .tag(func_s1),
		.out_valid(hash_v), .quot(hash_quot), .rem(hash_rem), .tag_out(hash_tag)
	);

	// ---------------- stages 6..9: offset fraction (m+1)/cell ----------------
	logic [1:0][CELL_W-1:0] frac_r0;
	logic [1:0]             full;
	frac_tag_t              frac_in_tag;
	logic                   frac_v;
	logic [1:0][15:0]       frac_quot;
	logic [1:0][CELL_W-1:0] frac_rem;
	frac_tag_t              frac_tag;

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			// m+1 equal to the cell size gives exactly one
			full[a]    = (mod_rem[a] + CELL_W'(1)) == cs;
			frac_r0[a] = full[a] ? '0 : mod_rem[a] + CELL_W'(1);
		end
		frac_in_tag.func   = hash_tag;
		frac_in_tag.load   = mod_tag;
		frac_in_tag.full_x = full[0];
		frac_in_tag.full_y = full[1];
		for (int c = 0; c < 4; c++) begin
			frac_in_tag.idx[c] = IDX_W'(hash_rem[c]);
		end
	end

	pgn_div #(
		.LANES(2), .NUM_W(16), .DEN_W(CELL_W), .TAG_W($bits(frac_tag_t)), .STAGES(4)
	) u_frac_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(mod_v && hash_v), .r0(frac_r0), .num('0), .den(cs), .tag(frac_in_tag),
		.out_valid(frac_v), .quot(frac_quot), .rem(frac_rem), .tag_out(frac_tag)
	);

	// ---------------- stage 10: gradient table ----------------
	logic [31:0] mem_a [TABLE_DEPTH];
	logic [31:0] mem_b [TABLE_DEPTH];
	logic        v_s10;
	logic [31:0] g_s10 [4];
	logic [16:0] dx_s10, dy_s10;
	logic        tbl_we;

	assign tbl_we = frac_v && (frac_tag.func == FUNC_LOAD)
		&& (32'(frac_tag.load.grad_index) < TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (en) begin
			if (tbl_we) begin
				mem_a[IDX_W'(frac_tag.load.grad_index)] <=
					{frac_tag.load.grad_y, frac_tag.load.grad_x};
				mem_b[IDX_W'(frac_tag.load.grad_index)] <=
					{frac_tag.load.grad_y, frac_tag.load.grad_x};
			end
			g_s10[0] <= mem_a[frac_tag.idx[0]];
			g_s10[1] <= mem_a[frac_tag.idx[1]];
			g_s10[2] <= mem_b[frac_tag.idx[2]];
			g_s10[3] <= mem_b[frac_tag.idx[3]];
			dx_s10   <= frac_tag.full_x ? 17'(FIX_ONE) : {1'b0, frac_quot[0]};
			dy_s10   <= frac_tag.full_y ? 17'(FIX_ONE) : {1'b0, frac_quot[1]};
		end
	end

	// ---------------- stage 11: dot products, fade first step ----------------
	logic signed [17:0] ox0, ox1, oy0, oy1;
	logic signed [34:0] dot [4];
	logic signed [20:0] bx, by;
	logic [16:0]        t2x, t2y;

	function automatic logic signed [20:0] fade_b(input logic [16:0] t);
		logic signed [21:0] a;
		logic signed [39:0] ta;
		logic signed [23:0] b;
		a  = 22'($signed({1'b0, t})) * 22'sd6 - 22'sd983040;
		ta = 40'($signed({1'b0, t})) * 40'(a);
		b  = $signed(ta[39:16]) + 24'sd655360;
		return b[20:0];
	endfunction

	function automatic logic [16:0] mul_q16(input logic [16:0] p, input logic [16:0] r);
		logic [33:0] m;
		m = 34'(p) * 34'(r);
		return m[32:16];
	endfunction

	function automatic logic signed [34:0] dot2(input logic [31:0] g,
		input logic signed [17:0] ox, input logic signed [17:0] oy);
		logic signed [33:0] px, py;
		px = 34'($signed(g[15:0])) * 34'(ox);
		py = 34'($signed(g[31:16])) * 34'(oy);
		return 35'(px) + 35'(py);
	endfunction

	assign ox0 = $signed({1'b0, dx_s10});
	assign oy0 = $signed({1'b0, dy_s10});
	assign ox1 = ox0 - 18'sd65536;
	assign oy1 = oy0 - 18'sd65536;

	always_comb begin
		dot[0] = dot2(g_s10[0], ox0, oy0);
		dot[1] = dot2(g_s10[1], ox1, oy0);
		dot[2] = dot2(g_s10[2], ox0, oy1);
		dot[3] = dot2(g_s10[3], ox1, oy1);
		bx     = fade_b(dx_s10);
		by     = fade_b(dy_s10);
		t2x    = mul_q16(dx_s10, dx_s10);
		t2y    = mul_q16(dy_s10, dy_s10);
	end

	logic               v_s11;
	logic signed [34:0] dot_s11 [4];
	logic signed [20:0] bx_s11, by_s11;
	logic [16:0]        t2x_s11, t2y_s11, tx_s11, ty_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s11 <= dot;
			bx_s11  <= bx;
			by_s11  <= by;
			t2x_s11 <= t2x;
			t2y_s11 <= t2y;
			tx_s11  <= dx_s10;
			ty_s11  <= dy_s10;
		end
	end

	// ---------------- stage 12: t cubed ----------------
	logic               v_s12;
	logic signed [34:0] dot_s12 [4];
	logic signed [20:0] bx_s12, by_s12;
	logic [16:0]        t3x_s12, t3y_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s12 <= dot_s11;
			bx_s12  <= bx_s11;
			by_s12  <= by_s11;
			t3x_s12 <= mul_q16(t2x_s11, tx_s11);
			t3y_s12 <= mul_q16(t2y_s11, ty_s11);
		end
	end

	// ---------------- stage 13: fade result ----------------
	logic signed [38:0] fxp, fyp;
	logic               v_s13;
	logic signed [34:0] dot_s13 [4];
	logic signed [17:0] u_s13, w_s13;

	assign fxp = 39'($signed({1'b0, t3x_s12})) * 39'(bx_s12);
	assign fyp = 39'($signed({1'b0, t3y_s12})) * 39'(by_s12);

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s13 <= dot_s12;
			u_s13   <= $signed(fxp[33:16]);
			w_s13   <= $signed(fyp[33:16]);
		end
	end

	// ---------------- stages 14, 15: lerp along x ----------------
	logic signed [35:0] diff_b, diff_t;
	logic               v_s14;
	logic signed [53:0] prodb_s14, prodt_s14;
	logic signed [34:0] bl_s14, tl_s14;
	logic signed [17:0] w_s14;

	assign diff_b = 36'(dot_s13[1]) - 36'(dot_s13[0]);
	assign diff_t = 36'(dot_s13[3]) - 36'(dot_s13[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			prodb_s14 <= 54'(u_s13) * 54'(diff_b);
			prodt_s14 <= 54'(u_s13) * 54'(diff_t);
			bl_s14    <= dot_s13[0];
			tl_s14    <= dot_s13[2];
			w_s14     <= w_s13;
		end
	end

	logic               v_s15;
	logic signed [35:0] xb_s15, xt_s15;
	logic signed [17:0] w_s15;

	always_ff @(posedge clk) begin
		if (en) begin
			xb_s15 <= 36'(38'(bl_s14) + $signed(prodb_s14[53:16]));
			xt_s15 <= 36'(38'(tl_s14) + $signed(prodt_s14[53:16]));
			w_s15  <= w_s14;
		end
	end

	// ---------------- stages 16, 17: lerp along y ----------------
	logic signed [36:0] diff_v;
	logic               v_s16;
	logic signed [54:0] prodv_s16;
	logic signed [35:0] xb_s16;

	assign diff_v = 37'(xt_s15) - 37'(xb_s15);

	always_ff @(posedge clk) begin
		if (en) begin
			prodv_s16 <= 55'(w_s15) * 55'(diff_v);
			xb_s16    <= xb_s15;
		end
	end

	logic               v_s17;
	logic signed [36:0] val_s17;

	always_ff @(posedge clk) begin
		if (en) begin
			val_s17 <= 37'(39'(xb_s16) + $signed(prodv_s16[54:16]));
		end
	end

	// ---------------- stage 18: weight ----------------
	logic               v_s18;
	logic signed [53:0] sc_s18;

	always_ff @(posedge clk) begin
		if (en) begin
			sc_s18 <= 54'(val_s17) * 54'($signed({1'b0, layer_weight_q}));
		end
	end

	// ---------------- output register: shift and saturate ----------------
	logic signed [31:0]      sh;
	logic signed [OUT_W-1:0] sat;
	logic signed [OUT_W-1:0] noise_value_q;

	assign sh = $signed(sc_s18[53:22]);

	always_comb begin
		if (sh > 32'sd67108863) begin
			sat = {1'b0, {(OUT_W-1){1'b1}}};
		end else if (sh < -32'sd67108864) begin
			sat = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			sat = sh[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			noise_value_q <= sat;
		end
	end

	assign noise_value = noise_value_q;

	// valid bits; load requests drop out at the table stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10       <= 1'b0;
			v_s11       <= 1'b0;
			v_s12       <= 1'b0;
			v_s13       <= 1'b0;
			v_s14       <= 1'b0;
			v_s15       <= 1'b0;
			v_s16       <= 1'b0;
			v_s17       <= 1'b0;
			v_s18       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s10       <= frac_v && (frac_tag.func == FUNC_EVAL);
			v_s11       <= v_s10;
			v_s12       <= v_s11;
			v_s13       <= v_s12;
			v_s14       <= v_s13;
			v_s15       <= v_s14;
			v_s16       <= v_s15;
			v_s17       <= v_s16;
			v_s18       <= v_s17;
			out_valid_q <= v_s18;
		end
	end

endmodule

// ----- hdl/pgn_checker.sv -----
// Port-level checks of the noise block, bound to its top level.
`include "assert_macros.svh"

module pgn_checker
	import pgn_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    func,
	input logic [15:0]             pixel_x,
	input logic [15:0]             pixel_y,
	input logic [11:0]             cell_x,
	input logic [11:0]             cell_y,
	input logic [7:0]              grad_index,
	input logic signed [15:0]      grad_x,
	input logic signed [15:0]      grad_y,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [OUT_W-1:0] noise_value,
	input logic                    cfg_valid,
	input logic                    cfg_ready,
	input logic [CFG_IDX_W-1:0]    cfg_index,
	input logic [CFG_DATA_W-1:0]   cfg_data
);

	// input side stalls only behind a result that is itself stalled
	`PGN_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> (out_valid && out_stall), "input stalled without output backpressure")

	`PGN_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(noise_value), "stalled result changed")

	`PGN_ASSERT(a_cfg_ready, clk, arst_n, cfg_valid |-> cfg_ready, "configuration write refused")

endmodule

bind perlin_gradient_noise_2d pgn_checker u_pgn_checker (.*);
